/* sv/tlt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the tabu list table.
`default_nettype none
package tlt_pkg;

    localparam int DEPTH     = 16;
    localparam int NODE_BITS = 10;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TEN_W     = 8;
    localparam int CAP_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int CMD_W     = 3;
    localparam int CFG_W     = 8;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [TEN_W-1:0] TENURE_RST   = TEN_W'(7);
    localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_TICK   = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_FINDRM = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic {
        CFG_TENURE   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic mark;
        logic squeeze;
        logic evict;
        logic append;
        logic clear;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic             any_kill;
        logic             full;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
    } t_dp_stat;

endpackage
`default_nettype wire

/* sv/tlt_ctrl.sv */
// Sequencer for the tabu list table: steps each command word through the datapath.
`default_nettype none
module tlt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  tlt_pkg::t_dp_stat i_stat,
    output tlt_pkg::t_dp_cmd  o_cmd
);
    import tlt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_MARK    = 5'b00010,
        S_SQUEEZE = 5'b00100,
        S_ADD     = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                priority if (i_stat.cmd == CMD_ADD) begin
                    n_state = S_ADD;
                end else if (i_stat.cmd == CMD_TICK || i_stat.cmd == CMD_FINDRM) begin
                    n_state = S_SQUEEZE;
                end else if (i_stat.cmd == CMD_CLEAR) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQUEEZE: begin
                // drop one marked entry per cycle
                if (i_stat.any_kill) begin
                    o_cmd.squeeze = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ADD: begin
                if (i_stat.full) begin
                    o_cmd.evict = 1'b1;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* sv/tlt_dp.sv */
// Datapath of the tabu list table: entry cells, compare, compaction shift and result register.
`default_nettype none
module tlt_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  tlt_pkg::t_dp_cmd              i_cmd,
    output tlt_pkg::t_dp_stat             o_stat,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_idx,
    input  wire [tlt_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire [tlt_pkg::CMD_W-1:0]      i_cmd_word,
    input  wire [tlt_pkg::NODE_BITS-1:0]  i_node_a,
    input  wire [tlt_pkg::NODE_BITS-1:0]  i_node_b,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_hit,
    output logic [tlt_pkg::COUNT_W-1:0]   o_count
);
    import tlt_pkg::*;

    logic [TEN_W-1:0]     r_tenure;
    logic [CAP_W-1:0]     r_capacity;
    logic [CMD_W-1:0]     r_cmd;
    logic [NODE_BITS-1:0] r_a, r_b;

    logic [NODE_BITS-1:0] r_first  [DEPTH];
    logic [NODE_BITS-1:0] r_second [DEPTH];
    logic [TEN_W-1:0]     r_rem    [DEPTH];
    logic [NODE_BITS-1:0] n_first  [DEPTH];
    logic [NODE_BITS-1:0] n_second [DEPTH];
    logic [TEN_W-1:0]     n_rem    [DEPTH];
    logic [NODE_BITS-1:0] up_first  [DEPTH];
    logic [NODE_BITS-1:0] up_second [DEPTH];
    logic [TEN_W-1:0]     up_rem    [DEPTH];
    logic [DEPTH-1:0]     r_kill, n_kill, up_kill;
    logic [DEPTH-1:0]     prefix, shift_en;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_hit, n_hit;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;

    logic [CMP_W-1:0]     cap_ext, cap_eff, cnt_ext;
    logic                 is_tick, is_find, is_findrm;
    logic [DEPTH-1:0]     valid_mask, pair_match, node_touch;

    // neighbor above each cell, for the shift-down compaction
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_up
            if (g < DEPTH - 1) begin : g_mid
                assign up_first[g]  = r_first[g+1];
                assign up_second[g] = r_second[g+1];
                assign up_rem[g]    = r_rem[g+1];
                assign up_kill[g]   = r_kill[g+1];
            end else begin : g_top
                assign up_first[g]  = '0;
                assign up_second[g] = '0;
                assign up_rem[g]    = '0;
                assign up_kill[g]   = 1'b0;
            end
        end
    endgenerate

    assign is_tick   = (r_cmd == CMD_TICK);
    assign is_find   = (r_cmd == CMD_FIND);
    assign is_findrm = (r_cmd == CMD_FINDRM);

    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        cnt_ext = CMP_W'(r_count);
        priority if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_mask[i] = (CNT_W'(i) < r_count);
            pair_match[i] = valid_mask[i] &&
                            ((r_first[i] == r_a && r_second[i] == r_b) ||
                             (r_first[i] == r_b && r_second[i] == r_a));
            node_touch[i] = valid_mask[i] &&
                            (r_first[i] == r_a || r_first[i] == r_b ||
                             r_second[i] == r_a || r_second[i] == r_b);
        end
    end

    // on squeeze the lowest marked entry and everything above it move down one place; on evict all do
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            acc       = acc | r_kill[i];
            prefix[i] = acc;
        end
        shift_en = i_cmd.evict ? '1 : (i_cmd.squeeze ? prefix : '0);
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_first[i]  = r_first[i];
            n_second[i] = r_second[i];
            n_rem[i]    = r_rem[i];
            n_kill[i]   = r_kill[i];
            if (i_cmd.mark) begin
                if (is_tick) begin
                    n_kill[i] = valid_mask[i] && (r_rem[i] <= TEN_W'(1));
                    if (valid_mask[i] && r_rem[i] > TEN_W'(1)) begin
                        n_rem[i] = r_rem[i] - TEN_W'(1);
                    end
                end else if (is_findrm) begin
                    n_kill[i] = node_touch[i];
                end else begin
                    n_kill[i] = 1'b0;
                end
            end else if (shift_en[i]) begin
                n_first[i]  = up_first[i];
                n_second[i] = up_second[i];
                n_rem[i]    = up_rem[i];
                n_kill[i]   = up_kill[i];
            end
            if (i_cmd.append && CNT_W'(i) == r_count) begin
                n_first[i]  = r_a;
                n_second[i] = r_b;
                n_rem[i]    = r_tenure;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.squeeze || i_cmd.evict) begin
            n_count = r_count - CNT_W'(1);
        end else if (i_cmd.append) begin
            n_count = r_count + CNT_W'(1);
        end
        n_hit = r_hit;
        if (i_cmd.mark) begin
            n_hit = (is_find && (|pair_match)) || (is_findrm && (|node_touch));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_first[i]  <= n_first[i];
            r_second[i] <= n_second[i];
            r_rem[i]    <= n_rem[i];
        end
        r_hit <= n_hit;
        if (i_cmd.capture) begin
            r_cmd <= i_cmd_word;
            r_a   <= i_node_a;
            r_b   <= i_node_b;
        end
        if (i_cmd.load_out) begin
            r_out_count <= cnt_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_kill      <= '0;
            r_tenure    <= TENURE_RST;
            r_capacity  <= CAPACITY_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_kill  <= n_kill;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TENURE:   r_tenure   <= i_cfg_data[TEN_W-1:0];
                    CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                    default:      r_tenure   <= r_tenure;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_hit <= r_hit;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_count         = r_out_count;
    assign o_stat.any_kill = |r_kill;
    assign o_stat.full     = (cnt_ext >= cap_eff);
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_stat.cmd      = r_cmd;

endmodule
`default_nettype wire

/* sv/tabu_list_table_core.sv */
// Top level of the tabu list table: controller and datapath joined by command and status.
//
// Usage: one command word enters on i_valid/o_ready (i_cmd, i_node_a, i_node_b) and
// exactly one result word leaves on o_valid/i_ready (o_hit, o_count). Commands are
// add, tick, find, find-and-remove and clear; unknown codes change nothing, hit 0.
// Configuration (tenure, capacity) is written through i_cfg_we/i_cfg_idx/i_cfg_data
// while the block is idle; there is no read-back.
//
// Steps, from the accept to the next accept: find, clear and unknown codes pass
// through capture, mark and done; tick and find-and-remove add a squeeze step in
// which the compaction shifter drops one entry per cycle until none is marked; add
// takes an add step that evicts the oldest entries one at a time while the table
// is full (normally none or one), then appends. The result word shows on o_valid in the cycle after the last step.
//
// The result sits in an output register, so a new command word is taken while the
// previous result still waits. If the receiver stalls, hold the next result inside
// until the output register is free; the input then stops after one more word.
// Reset (synchronous, active low) empties the table, restores tenure 7 and capacity
// 16 and drops any pending result. Entry contents need no clearing pass.
`default_nettype none
module tabu_list_table_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_idx,
    input  wire [tlt_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire [tlt_pkg::CMD_W-1:0]      i_cmd,
    input  wire [tlt_pkg::NODE_BITS-1:0]  i_node_a,
    input  wire [tlt_pkg::NODE_BITS-1:0]  i_node_b,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_hit,
    output logic [tlt_pkg::COUNT_W-1:0]   o_count
);
    import tlt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: one step of the datapath per cycle
    tlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // entry cells, parallel compare, shift-down compaction, result register
    tlt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd_word (i_cmd),
        .i_node_a   (i_node_a),
        .i_node_b   (i_node_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_count    (o_count)
    );

endmodule
`default_nettype wire

/* verif/tabu_list_table_core_tb.sv */
// Self-checking testbench for tabu_list_table_core: directed script plus random phases.
`default_nettype none
module tabu_list_table_core_tb;
    import tlt_pkg::*;

    // Command codes the block must ignore: nothing changes, hit stays low.
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int NODE_MAX   = (1 << NODE_BITS) - 1;
    localparam int SETTLE_CYC = 4;   // pad after the last result before a register write
    localparam int TAIL_CYC   = 40;  // pad at the end, above the slowest command

    // One result word: hit flag and entry count after the command.
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } t_status;

    // One line of the directed script: either a register write or a command word,
    // with the result typed in where it is obvious.
    typedef struct packed {
        logic                 is_reg;
        t_cfg_idx             reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [CMD_W-1:0]     cmd;
        logic [NODE_BITS-1:0] a;
        logic [NODE_BITS-1:0] b;
        logic                 typed;
        t_status              want;
    } t_script_line;

    // One random phase: register settings, idling mix, add share and length.
    typedef struct packed {
        logic [CFG_W-1:0] tenure;
        logic [CFG_W-1:0] cap;
        int unsigned      send_pct;
        int unsigned      recv_pct;
        int unsigned      add_pct;
        int unsigned      words;
    } t_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_idx = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [NODE_BITS-1:0] i_node_a = '0;
    logic [NODE_BITS-1:0] i_node_b = '0;
    logic                 i_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_hit;
    logic [COUNT_W-1:0]   o_count;

    // Shadow copy of the table, kept in insertion order, oldest at index 0.
    logic [NODE_BITS-1:0] pair_first  [DEPTH];
    logic [NODE_BITS-1:0] pair_second [DEPTH];
    logic [TEN_W-1:0]     pair_left   [DEPTH];
    int                   pair_count = 0;
    logic [TEN_W-1:0]     shadow_tenure = TENURE_RST;
    logic [CAP_W-1:0]     shadow_capacity = CAPACITY_RST;

    t_status      owed_status[$];
    t_script_line script[$];
    t_phase       phases[$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int           n_mismatch = 0;

    tabu_list_table_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_node_a   (i_node_a),
        .i_node_b   (i_node_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_count    (o_count)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        n_mismatch++;
    endtask

    // Keep the flagged entries, close the gaps, preserve order.
    function automatic void squeeze_pairs(input logic [DEPTH-1:0] keep);
        int w;
        w = 0;
        for (int r = 0; r < pair_count; r++) begin
            if (keep[r]) begin
                pair_first[w]  = pair_first[r];
                pair_second[w] = pair_second[r];
                pair_left[w]   = pair_left[r];
                w++;
            end
        end
        pair_count = w;
    endfunction

    // Apply one command to the shadow table and return the result word it yields.
    function automatic t_status apply_tabu_cmd(input logic [CMD_W-1:0] cmd,
                                               input logic [NODE_BITS-1:0] a,
                                               input logic [NODE_BITS-1:0] b);
        t_status          res;
        logic [DEPTH-1:0] keep;
        int               cap;
        int               drop;
        res.hit = 1'b0;
        keep = '1;
        case (cmd)
            CMD_ADD: begin
                // Zero capacity acts as one, anything above the depth as the depth.
                cap = (shadow_capacity == 0) ? 1 : int'(shadow_capacity);
                if (cap > DEPTH) cap = DEPTH;
                if (pair_count >= cap) begin
                    drop = pair_count - cap + 1;
                    for (int i = 0; i < DEPTH; i++) keep[i] = (i >= drop);
                    squeeze_pairs(keep);
                end
                if (pair_count < DEPTH) begin
                    pair_first[pair_count]  = a;
                    pair_second[pair_count] = b;
                    pair_left[pair_count]   = shadow_tenure;
                    pair_count++;
                end
            end
            CMD_TICK: begin
                // Remaining of zero or one expires; no wrap below zero.
                for (int i = 0; i < pair_count; i++) begin
                    if (pair_left[i] <= 1) begin
                        pair_left[i] = '0;
                        keep[i] = 1'b0;
                    end else begin
                        pair_left[i]--;
                    end
                end
                squeeze_pairs(keep);
            end
            CMD_FIND: begin
                for (int i = 0; i < pair_count; i++) begin
                    if ((pair_first[i] == a && pair_second[i] == b) ||
                        (pair_first[i] == b && pair_second[i] == a))
                        res.hit = 1'b1;
                end
            end
            CMD_FINDRM: begin
                for (int i = 0; i < pair_count; i++) begin
                    if (pair_first[i] == a || pair_first[i] == b ||
                        pair_second[i] == a || pair_second[i] == b) begin
                        keep[i] = 1'b0;
                        res.hit = 1'b1;
                    end
                end
                squeeze_pairs(keep);
            end
            CMD_CLEAR: pair_count = 0;
            default: ;
        endcase
        res.count = COUNT_W'(pair_count);
        return res;
    endfunction

    function automatic t_script_line line_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        t_script_line l;
        l = '0;
        l.is_reg  = 1'b1;
        l.reg_idx = idx;
        l.reg_val = val;
        return l;
    endfunction

    function automatic t_script_line line_cmd(input logic [CMD_W-1:0] cmd,
                                              input int a, input int b);
        t_script_line l;
        l = '0;
        l.cmd = cmd;
        l.a   = NODE_BITS'(a);
        l.b   = NODE_BITS'(b);
        return l;
    endfunction

    function automatic t_script_line line_chk(input logic [CMD_W-1:0] cmd, input int a,
                                              input int b, input logic hit, input int count);
        t_script_line l;
        l = line_cmd(cmd, a, b);
        l.typed      = 1'b1;
        l.want.hit   = hit;
        l.want.count = COUNT_W'(count);
        return l;
    endfunction

    function automatic t_phase make_phase(input int tenure, input int cap, input int send_pct,
                                          input int recv_pct, input int add_pct, input int words);
        t_phase p;
        p.tenure   = CFG_W'(tenure);
        p.cap      = CFG_W'(cap);
        p.send_pct = send_pct;
        p.recv_pct = recv_pct;
        p.add_pct  = add_pct;
        p.words    = words;
        return p;
    endfunction

    // Append one line to the end of the directed script.
    function automatic void add_line(input t_script_line l);
        script = {script, l};
    endfunction

    // Append one random phase to the schedule.
    function automatic void add_phase(input t_phase p);
        phases = {phases, p};
    endfunction

    // Drop valid, let every owed result drain, then let the block idle for the given pad.
    task automatic drain_results(input int pad);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (owed_status.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    // Register write: one cycle of write enable, then update the shadow settings.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TENURE) shadow_tenure = TEN_W'(val);
        else shadow_capacity = CAP_W'(val);
    endtask

    // Offer one command word, hold it until taken, then record what it must yield.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_BITS-1:0] a,
                             input logic [NODE_BITS-1:0] b, input logic typed,
                             input t_status typed_want);
        t_status predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_cmd    = cmd;
        i_node_a = a;
        i_node_b = b;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_tabu_cmd(cmd, a, b);
        if (typed) predicted = typed_want;
        owed_status = {owed_status, predicted};
    endtask

    // Mostly a small pool so pairs collide and finds hit; now and then the full range.
    function automatic logic [NODE_BITS-1:0] pick_node();
        if ($urandom_range(0, 99) < 75) return NODE_BITS'($urandom_range(0, 11));
        return NODE_BITS'($urandom_range(0, NODE_MAX));
    endfunction

    task automatic send_random_word(input int unsigned add_pct);
        logic [CMD_W-1:0]     cmd;
        logic [NODE_BITS-1:0] a;
        logic [NODE_BITS-1:0] b;
        int                   roll;
        int                   k;
        a = pick_node();
        b = pick_node();
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            cmd = CMD_ADD;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      cmd = CMD_TICK;
            else if (roll < 75) cmd = CMD_FIND;
            else if (roll < 90) cmd = CMD_FINDRM;
            else if (roll < 95) cmd = CMD_CLEAR;
            else begin
                roll = $urandom_range(0, 2);
                cmd = (roll == 0) ? CMD_SPARE5 : (roll == 1) ? CMD_SPARE6 : CMD_SPARE7;
            end
        end
        // Aim finds at held pairs, in either orientation, and removals at held nodes.
        if (pair_count > 0) begin
            k = $urandom_range(0, pair_count - 1);
            if (cmd == CMD_FIND && $urandom_range(0, 1)) begin
                if ($urandom_range(0, 1)) begin
                    a = pair_first[k];
                    b = pair_second[k];
                end else begin
                    a = pair_second[k];
                    b = pair_first[k];
                end
            end else if (cmd == CMD_FINDRM && $urandom_range(0, 99) < 30) begin
                a = $urandom_range(0, 1) ? pair_first[k] : pair_second[k];
            end
        end
        send_word(cmd, a, b, 1'b0, '0);
    endtask

    // Receiver: stall at random, decided at the falling edge.
    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result word with the oldest one owed, field by field.
    always @(posedge i_clk) begin : result_check
        t_status want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_status.size() == 0) begin
                log_mismatch($sformatf("result word hit=%0b count=%0d with none owed",
                                       o_hit, o_count));
            end else begin
                want = owed_status.pop_front();
                if (o_hit !== want.hit)
                    log_mismatch($sformatf("hit %0b, expected %0b", o_hit, want.hit));
                if (o_count !== want.count)
                    log_mismatch($sformatf("count %0d, expected %0d", o_count, want.count));
            end
        end
    end

    initial begin
        #3000000;
        $display("FAIL tabu_list_table_core");
        $finish;
    end

    initial begin
        // Directed script: empty table, both orientations, ignored codes, removal by node,
        // clear, zero and one tenure, capacity zero / above depth / lowered below count.
        add_line(line_chk(CMD_FIND, 0, 0, 1'b0, 0));
        add_line(line_chk(CMD_TICK, 0, 0, 1'b0, 0));
        add_line(line_chk(CMD_FINDRM, NODE_MAX, NODE_MAX, 1'b0, 0));
        add_line(line_chk(CMD_ADD, 0, NODE_MAX, 1'b0, 1));
        add_line(line_chk(CMD_FIND, NODE_MAX, 0, 1'b1, 1));
        add_line(line_chk(CMD_FIND, 0, 0, 1'b0, 1));
        add_line(line_chk(CMD_SPARE5, 0, NODE_MAX, 1'b0, 1));
        add_line(line_chk(CMD_SPARE6, 0, NODE_MAX, 1'b0, 1));
        add_line(line_chk(CMD_SPARE7, NODE_MAX, 0, 1'b0, 1));
        add_line(line_chk(CMD_ADD, NODE_MAX, 0, 1'b0, 2));
        add_line(line_chk(CMD_ADD, 5, 6, 1'b0, 3));
        add_line(line_chk(CMD_FINDRM, 6, 900, 1'b1, 2));
        add_line(line_chk(CMD_CLEAR, NODE_MAX, NODE_MAX, 1'b0, 0));
        add_line(line_reg(CFG_TENURE, 8'd0));
        add_line(line_chk(CMD_ADD, 3, 4, 1'b0, 1));
        add_line(line_reg(CFG_TENURE, 8'd1));
        add_line(line_chk(CMD_ADD, 7, 8, 1'b0, 2));
        add_line(line_chk(CMD_TICK, 0, 0, 1'b0, 0));
        add_line(line_reg(CFG_TENURE, 8'd255));
        add_line(line_reg(CFG_CAPACITY, 8'd0));
        add_line(line_chk(CMD_ADD, 1, 2, 1'b0, 1));
        add_line(line_chk(CMD_ADD, 3, 4, 1'b0, 1));
        add_line(line_chk(CMD_FIND, 1, 2, 1'b0, 1));
        add_line(line_reg(CFG_CAPACITY, 8'd31));
        add_line(line_cmd(CMD_ADD, 10, 11));
        add_line(line_cmd(CMD_ADD, 12, 13));
        add_line(line_cmd(CMD_ADD, 14, 15));
        add_line(line_cmd(CMD_ADD, NODE_MAX, NODE_MAX));
        add_line(line_reg(CFG_CAPACITY, 8'hE2));  // upper bits dropped, capacity 2
        add_line(line_cmd(CMD_ADD, 9, 9));
        add_line(line_cmd(CMD_TICK, 0, 0));

        // Random phases: tenure, capacity, sender idle %, receiver stall %, add %, words.
        add_phase(make_phase(3, 4, 0, 0, 55, 120));
        add_phase(make_phase(20, 16, 72, 0, 60, 120));
        add_phase(make_phase(255, 31, 0, 72, 75, 120));
        add_phase(make_phase(0, 1, 7, 7, 55, 100));
        add_phase(make_phase(1, 17, 0, 0, 60, 100));
        add_phase(make_phase($urandom_range(0, 255), $urandom_range(0, 255),
                             0, 72, 60, 130));
        add_phase(make_phase(200, 16, 72, 0, 85, 120));
        // Capacity drops far below the count left by the fill phase above.
        add_phase(make_phase(5, 2, 7, 7, 55, 140));

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[n]) begin
            if (script[n].is_reg) begin
                drain_results(SETTLE_CYC);
                write_reg(script[n].reg_idx, script[n].reg_val);
            end else begin
                send_word(script[n].cmd, script[n].a, script[n].b,
                          script[n].typed, script[n].want);
            end
        end

        foreach (phases[p]) begin
            drain_results(SETTLE_CYC);
            write_reg(CFG_TENURE, phases[p].tenure);
            write_reg(CFG_CAPACITY, phases[p].cap);
            send_idle_pct  = phases[p].send_pct;
            recv_stall_pct = phases[p].recv_pct;
            for (int w = 0; w < phases[p].words; w++) begin
                // Now and then hold off until every owed result is back.
                if ($urandom_range(0, 199) == 0) drain_results(0);
                send_random_word(phases[p].add_pct);
            end
        end

        drain_results(TAIL_CYC);
        if (n_mismatch == 0) begin
            $display("PASS tabu_list_table_core");
        end else begin
            $display("FAIL tabu_list_table_core");
        end
        $finish;
    end

endmodule
`default_nettype wire
